// ===== design/lcfd_pkg.sv =====
// shared types and constants for the lightmap coverage fix and dilate block
// no dependencies
package lcfd_pkg;

  localparam int ColorBits     = 16;
  localparam int CoverFracBits = 14;
  localparam int CoverBits     = 16;
  localparam int DivBits       = ColorBits + CoverFracBits;
  localparam int SumBits       = ColorBits + 3;
  localparam int CountBits     = 4;
  localparam int CfgBits       = 11;
  localparam int CfgIdxBits    = 1;
  localparam int MaxWidthDef   = 1024;
  localparam int HeightLimit   = 1024;
  localparam int HeightBits    = $clog2(HeightLimit + 1);

  localparam logic [CoverBits-1:0] CoverOne = CoverBits'(1) << CoverFracBits;
  localparam logic [ColorBits-1:0] ColorMax = '1;

  localparam logic [CfgIdxBits-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegHeight = 1'b1;

  localparam logic OpTexel = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef logic [2:0][ColorBits-1:0] rgb_t;

  typedef struct packed {
    logic covered;
    rgb_t chan;
  } texel_t;

endpackage

// ===== design/lightmap_coverage_fix_and_dilate_top.sv =====
// lightmap coverage fix with 3x3 dilation of uncovered texels
// depends on lcfd_pkg; holds the row store memory and the shared divider
// latency: a texel result leaves raster_width + 1 input beats after it arrives,
// the last raster_width + 1 results are pulled out by flush beats
// throughput: a new beat is taken only once the last one is done; partial coverage runs the
// 30-step radix-2 divider, shared by three channels; a beat that emits adds up to nine
// single-port reads of the row store, a divide for a dilated texel, plus any output stall
// reset: asynchronous active low, clears counters and sets width and height to 1024
module lightmap_coverage_fix_and_dilate_top #(
  parameter int MAX_WIDTH = lcfd_pkg::MaxWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // fields from bit 0: red_in, green_in, blue_in, coverage
  input  logic [63:0]                       s_axis_tdata,
  // fields from bit 0: operation
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: red_out, green_out, blue_out
  output logic [47:0]                       m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [lcfd_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [lcfd_pkg::CfgBits-1:0]      cfg_data_i
);

  // row store depth: two lines plus the window
  localparam int Depth = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(Depth);
  localparam int TW    = $clog2(3 * Depth);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = lcfd_pkg::HeightBits;
  localparam int PW    = $clog2(MAX_WIDTH + 3);
  localparam int CB    = lcfd_pkg::ColorBits;
  localparam int DB    = lcfd_pkg::DivBits;
  localparam int SB    = lcfd_pkg::SumBits;
  localparam int NB    = lcfd_pkg::CountBits;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WRITE, S_CTR_RD, S_CTR_WAIT,
    S_NB_RD, S_NB_WAIT, S_NB_DONE, S_LOAD
  } state_e;

  state_e state_q;

  // configuration, held raw and clamped on use
  logic [lcfd_pkg::CfgBits-1:0] width_cfg_q, height_cfg_q;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // arrival and emission positions
  logic [WW-1:0] col_q, e_col_q;
  logic [HW-1:0] row_q, e_row_q;
  logic [AW-1:0] w_addr_q, e_addr_q;
  logic [PW-1:0] pend_q;
  logic          draining_q, flush_q;

  // operands and per-texel work registers
  lcfd_pkg::rgb_t               in_q, chan_q;
  logic [lcfd_pkg::CoverBits-1:0] cov_q;
  logic [2:0][SB-1:0]           sum_q;
  logic [NB-1:0]                cnt_q;
  logic [3:0]                   k_q;
  logic                         mean_q;

  // shared divider
  logic [DB-1:0]  quo_q, quo_d;
  logic [CB-1:0]  rem_q;
  logic [CB-1:0]  dsr_q;
  logic [4:0]     step_q;
  logic [1:0]     ch_q, ch_nxt;
  logic [CB:0]    rem_sh, rem_sub;
  logic           ge;
  logic [CB-1:0]  div_res;
  logic [DB-1:0]  next_dvd;

  // memory
  lcfd_pkg::texel_t mem [Depth];
  lcfd_pkg::texel_t rd_q, wr_data;
  logic             wr_en, rd_en;
  logic [AW-1:0]    rd_addr, nb_addr;

  // output register
  logic [47:0] out_data_q;
  logic        out_last_q, out_valid_q;

  logic [15:0] in_cov;
  logic        in_needs_div;
  logic        frame_end;
  logic        nb_up, nb_dn, nb_lf, nb_rt, nb_ok;
  logic [TW-1:0] t_base, t_sum, t_red;

  // clamp width to 1..MAX_WIDTH, height to 1..limit
  always_comb begin
    if (width_cfg_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_cfg_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_cfg_q);
    end
    if (height_cfg_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_cfg_q) > 32'(lcfd_pkg::HeightLimit)) begin
      h_eff = HW'(lcfd_pkg::HeightLimit);
    end else begin
      h_eff = HW'(height_cfg_q);
    end
  end

  assign in_cov       = s_axis_tdata[63:48];
  assign in_needs_div = (in_cov != '0) && (in_cov < lcfd_pkg::CoverOne);
  assign frame_end    = (e_col_q == w_eff - WW'(1)) && (e_row_q == h_eff - HW'(1));

  // one restoring step of the divider
  assign rem_sh  = {rem_q, quo_q[DB-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  assign quo_d   = {quo_q[DB-2:0], ge};
  assign div_res = (quo_d[DB-1:CB] != '0) ? lcfd_pkg::ColorMax : quo_d[CB-1:0];
  assign ch_nxt  = ch_q + 2'd1;
  assign next_dvd = mean_q ? DB'(sum_q[ch_nxt])
                           : {in_q[ch_nxt], {lcfd_pkg::CoverFracBits{1'b0}}};

  // neighbour k of the 3x3 window, k = 3 * row + column, center skipped
  assign nb_up = k_q < 4'd3;
  assign nb_dn = k_q > 4'd5;
  assign nb_lf = (k_q == 4'd0) || (k_q == 4'd3) || (k_q == 4'd6);
  assign nb_rt = (k_q == 4'd2) || (k_q == 4'd5) || (k_q == 4'd8);
  assign nb_ok = (k_q != 4'd4)
               && !(nb_up && (e_row_q == '0))
               && !(nb_dn && (32'(e_row_q) + 1 >= 32'(h_eff)))
               && !(nb_lf && (e_col_q == '0))
               && !(nb_rt && (32'(e_col_q) + 1 >= 32'(w_eff)));

  // neighbour address modulo the store depth
  always_comb begin
    t_base = TW'(e_addr_q) + TW'(Depth);
    if (nb_up) begin
      t_base = t_base - TW'(w_eff);
    end else if (nb_dn) begin
      t_base = t_base + TW'(w_eff);
    end
    t_sum = t_base;
    if (nb_lf) begin
      t_sum = t_base - TW'(1);
    end else if (nb_rt) begin
      t_sum = t_base + TW'(1);
    end
    if (t_sum >= TW'(2 * Depth)) begin
      t_red = t_sum - TW'(2 * Depth);
    end else if (t_sum >= TW'(Depth)) begin
      t_red = t_sum - TW'(Depth);
    end else begin
      t_red = t_sum;
    end
    nb_addr = AW'(t_red);
  end

  assign wr_en   = state_q == S_WRITE;
  assign wr_data = '{covered: (cov_q != '0), chan: chan_q};
  assign rd_en   = (state_q == S_CTR_RD) || ((state_q == S_NB_RD) && nb_ok);
  assign rd_addr = (state_q == S_CTR_RD) ? e_addr_q : nb_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[w_addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      width_cfg_q  <= lcfd_pkg::CfgBits'(1024);
      height_cfg_q <= lcfd_pkg::CfgBits'(1024);
      col_q        <= '0;
      row_q        <= '0;
      e_col_q      <= '0;
      e_row_q      <= '0;
      w_addr_q     <= '0;
      e_addr_q     <= '0;
      pend_q       <= '0;
      draining_q   <= 1'b0;
      flush_q      <= 1'b0;
      mean_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      k_q          <= '0;
      ch_q         <= '0;
      step_q       <= '0;
      cnt_q        <= '0;
    end else begin
      // the load state sets valid itself
      if (out_valid_q && m_axis_tready && (state_q != S_LOAD)) begin
        out_valid_q <= 1'b0;
      end
      // a write restarts the frame
      if (cfg_we_i) begin
        if (cfg_index_i == lcfd_pkg::RegWidth) begin
          width_cfg_q <= cfg_data_i;
        end
        if (cfg_index_i == lcfd_pkg::RegHeight) begin
          height_cfg_q <= cfg_data_i;
        end
        col_q      <= '0;
        row_q      <= '0;
        e_col_q    <= '0;
        e_row_q    <= '0;
        w_addr_q   <= '0;
        e_addr_q   <= '0;
        pend_q     <= '0;
        draining_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == lcfd_pkg::OpTexel) begin
              if (!draining_q) begin
                in_q    <= s_axis_tdata[47:0];
                cov_q   <= in_cov;
                flush_q <= 1'b0;
                if (in_needs_div) begin
                  mean_q  <= 1'b0;
                  ch_q    <= '0;
                  step_q  <= '0;
                  rem_q   <= '0;
                  quo_q   <= {s_axis_tdata[15:0], {lcfd_pkg::CoverFracBits{1'b0}}};
                  dsr_q   <= in_cov;
                  state_q <= S_DIV;
                end else begin
                  chan_q  <= s_axis_tdata[47:0];
                  state_q <= S_WRITE;
                end
              end
            end else if (draining_q && (pend_q != '0)) begin
              flush_q <= 1'b1;
              state_q <= S_CTR_RD;
            end
          end
        end
        S_DIV: begin
          if (step_q == 5'(DB - 1)) begin
            chan_q[ch_q] <= div_res;
            if (ch_q == 2'd2) begin
              state_q <= mean_q ? S_LOAD : S_WRITE;
            end else begin
              ch_q   <= ch_nxt;
              step_q <= '0;
              rem_q  <= '0;
              quo_q  <= next_dvd;
            end
          end else begin
            quo_q  <= quo_d;
            rem_q  <= rem_sub[CB-1:0];
            step_q <= step_q + 5'd1;
          end
        end
        S_WRITE: begin
          w_addr_q <= (32'(w_addr_q) + 1 == Depth) ? '0 : w_addr_q + AW'(1);
          if (col_q + WW'(1) == w_eff) begin
            col_q <= '0;
            if (row_q + HW'(1) == h_eff) begin
              row_q      <= '0;
              draining_q <= 1'b1;
            end else begin
              row_q <= row_q + HW'(1);
            end
          end else begin
            col_q <= col_q + WW'(1);
          end
          pend_q <= pend_q + PW'(1);
          if (32'(pend_q) + 1 >= 32'(w_eff) + 2) begin
            state_q <= S_CTR_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_CTR_RD: begin
          pend_q <= pend_q - PW'(1);
          if (flush_q && (pend_q == PW'(1))) begin
            draining_q <= 1'b0;
          end
          state_q <= S_CTR_WAIT;
        end
        S_CTR_WAIT: begin
          chan_q <= rd_q.chan;
          if (rd_q.covered) begin
            state_q <= S_LOAD;
          end else begin
            sum_q   <= '0;
            cnt_q   <= '0;
            k_q     <= '0;
            state_q <= S_NB_RD;
          end
        end
        S_NB_RD: begin
          if (nb_ok) begin
            state_q <= S_NB_WAIT;
          end else if (k_q == 4'd8) begin
            state_q <= S_NB_DONE;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        S_NB_WAIT: begin
          if (rd_q.covered) begin
            for (int i = 0; i < 3; i++) begin
              sum_q[i] <= sum_q[i] + SB'(rd_q.chan[i]);
            end
            cnt_q <= cnt_q + NB'(1);
          end
          if (k_q == 4'd8) begin
            state_q <= S_NB_DONE;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= S_NB_RD;
          end
        end
        S_NB_DONE: begin
          if (cnt_q != '0) begin
            mean_q  <= 1'b1;
            ch_q    <= '0;
            step_q  <= '0;
            rem_q   <= '0;
            quo_q   <= DB'(sum_q[0]);
            dsr_q   <= CB'(cnt_q);
            state_q <= S_DIV;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= chan_q;
            out_last_q  <= frame_end;
            out_valid_q <= 1'b1;
            e_addr_q    <= (32'(e_addr_q) + 1 == Depth) ? '0 : e_addr_q + AW'(1);
            if (e_col_q + WW'(1) == w_eff) begin
              e_col_q <= '0;
              e_row_q <= (e_row_q + HW'(1) == h_eff) ? '0 : e_row_q + HW'(1);
            end else begin
              e_col_q <= e_col_q + WW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tvalid = out_valid_q;

endmodule

// ===== design/lcfd_checker.sv =====
// port-level checks for the lightmap coverage fix and dilate block
// depends on lightmap_coverage_fix_and_dilate_top, bound below
module lcfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // a stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // the sequencer only leaves idle on an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("busy without an accepted beat");

  // a new result is only loaded while the input side is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind lightmap_coverage_fix_and_dilate_top lcfd_checker u_lcfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== tb/tb_top.sv =====
// self-checking bench for the lightmap coverage fix and dilate block
// depends on lcfd_pkg and lightmap_coverage_fix_and_dilate_top
`timescale 1ns / 100ps

module tb_top;
  import lcfd_pkg::*;

  localparam int StoreDepth = 2 * MaxWidthDef + 4;
  localparam int SettleCycles = 300;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_end;
  } texel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = RegWidth;
  logic [CfgBits-1:0] cfg_data_i = '0;

  lightmap_coverage_fix_and_dilate_top dut (.*);

  always #2 clk_i = ~clk_i;

  // model of the block: raster settings, position counters and texel history
  int unsigned raster_w_reg, raster_h_reg;
  int unsigned col_pos, row_pos, waiting_texels;
  bit frame_draining;
  texel_t history [StoreDepth];
  texel_out_t corrected_q[$];

  int error_count = 0;
  int beats_sent = 0;
  int texels_checked = 0;
  int frames_done = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  function automatic int unsigned used_width();
    return (raster_w_reg < 1) ? 1 : (raster_w_reg > MaxWidthDef) ? MaxWidthDef : raster_w_reg;
  endfunction

  function automatic int unsigned used_height();
    return (raster_h_reg < 1) ? 1 : (raster_h_reg > HeightLimit) ? HeightLimit : raster_h_reg;
  endfunction

  // dilated output of raster position pos
  function automatic texel_out_t dilated_texel(int unsigned pos);
    int unsigned w, h, cnt;
    int r, c, rr, cc;
    logic [SumBits-1:0] sum [3];
    texel_t t, n;
    texel_out_t o;
    w = used_width();
    h = used_height();
    t = history[pos % StoreDepth];
    cnt = 0;
    sum = '{default: '0};
    r = pos / w;
    c = pos % w;
    if (!t.covered) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
            n = history[(rr * w + cc) % StoreDepth];
            if (n.covered) begin
              for (int k = 0; k < 3; k++) sum[k] += n.chan[k];
              cnt++;
            end
          end
        end
      end
      if (cnt > 0) for (int k = 0; k < 3; k++) t.chan[k] = ColorBits'(sum[k] / cnt);
    end
    o.red = t.chan[0];
    o.green = t.chan[1];
    o.blue = t.chan[2];
    o.frame_end = (pos == w * h - 1);
    return o;
  endfunction

  task automatic predict_beat(logic op, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              logic [15:0] cov);
    int unsigned w, h, pos;
    logic [DivBits-1:0] q;
    logic [15:0] chans [3];
    texel_t t;
    w = used_width();
    h = used_height();
    chans = '{r, g, b};
    if (op == OpTexel) begin
      if (frame_draining) return;
      pos = row_pos * w + col_pos;
      t.covered = (cov != 0);
      for (int k = 0; k < 3; k++) begin
        if (cov != 0 && cov < CoverOne) begin
          q = {chans[k], {CoverFracBits{1'b0}}} / cov;
          t.chan[k] = (q > ColorMax) ? ColorMax : q[ColorBits-1:0];
        end else begin
          t.chan[k] = chans[k];
        end
      end
      history[pos % StoreDepth] = t;
      waiting_texels++;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          frame_draining = 1;
        end
      end
      if (waiting_texels >= w + 2) begin
        corrected_q.push_back(dilated_texel(pos + 1 - waiting_texels));
        waiting_texels--;
      end
    end else if (frame_draining && waiting_texels != 0) begin
      corrected_q.push_back(dilated_texel(w * h - waiting_texels));
      waiting_texels--;
      if (waiting_texels == 0) begin
        frame_draining = 0;
        frames_done++;
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one beat into the block, with random sender gaps
  task automatic send_beat(logic op, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] cov);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {cov, b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat(op, r, g, b, cov);
    beats_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    stop_sending();
    wait (corrected_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write between frames; also restarts the stream
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = CfgBits'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegWidth) raster_w_reg = val & 11'h7ff;
    else raster_h_reg = val & 11'h7ff;
    col_pos = 0;
    row_pos = 0;
    waiting_texels = 0;
    frame_draining = 0;
  endtask

  task automatic set_raster(int unsigned w, int unsigned h);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  function automatic logic [15:0] rand_color();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // coverage: uncovered, partial, exactly one, above one
  function automatic logic [15:0] rand_cov();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 16'h0000;
    if (sel < 33) return 16'h0001;
    if (sel < 70) return 16'($urandom_range(16383, 1));
    if (sel < 77) return CoverOne;
    if (sel < 80) return 16'hffff;
    return 16'($urandom_range(65535, 16385));
  endfunction

  task automatic send_texel();
    send_beat(OpTexel, rand_color(), rand_color(), rand_color(), rand_cov());
  endtask

  task automatic send_flush();
    send_beat(OpFlush, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // whole frame, with stray flushes mid-frame and stray texels while draining
  task automatic send_frame(int unsigned w, int unsigned h, bit noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(19) == 0) send_flush();
      send_texel();
    end
    for (int i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(14) == 0) send_texel();
      send_flush();
    end
    if (noisy && $urandom_range(3) == 0) send_flush();
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker for every texel beat leaving the block
  always @(posedge clk_i) begin
    texel_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (corrected_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[15:0], 16'h0);
      end else begin
        want = corrected_q.pop_front();
        texels_checked++;
        if (m_axis_tdata[15:0] !== want.red) report_mismatch("red", m_axis_tdata[15:0], want.red);
        if (m_axis_tdata[31:16] !== want.green)
          report_mismatch("green", m_axis_tdata[31:16], want.green);
        if (m_axis_tdata[47:32] !== want.blue)
          report_mismatch("blue", m_axis_tdata[47:32], want.blue);
        if (m_axis_tlast !== want.frame_end)
          report_mismatch("frame_end", 16'(m_axis_tlast), 16'(want.frame_end));
      end
    end
  end

  // 3x3 raster covering every coverage class, an orphan texel, early and extra flushes
  task automatic test_directed();
    set_raster(3, 3);
    send_beat(OpFlush, 16'h0, 16'h0, 16'h0, 16'h0);  // flush before the frame is complete
    send_beat(OpTexel, 16'hffff, 16'hffff, 16'hffff, 16'h0001);
    send_beat(OpTexel, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OpTexel, 16'h1234, 16'h8000, 16'hffff, 16'h3fff);
    send_beat(OpTexel, 16'h0100, 16'h0200, 16'h0300, CoverOne);
    send_beat(OpTexel, 16'hffff, 16'h0000, 16'haaaa, 16'hffff);
    send_beat(OpTexel, 16'h5555, 16'h0001, 16'h7fff, 16'h2000);
    send_beat(OpTexel, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    send_beat(OpTexel, 16'h4321, 16'h8765, 16'hcba9, 16'h0000);
    send_beat(OpTexel, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    send_beat(OpTexel, 16'h1111, 16'h2222, 16'h3333, 16'h1000);  // ignored while draining
    repeat (4) send_flush();
    send_flush();  // nothing left to drain
    // uncovered texel with no covered neighbour keeps its color
    set_raster(2, 1);
    send_beat(OpTexel, 16'habcd, 16'h1357, 16'h2468, 16'h0000);
    send_beat(OpTexel, 16'h0f0f, 16'hf0f0, 16'h00ff, 16'h0000);
    repeat (3) send_flush();
  endtask

  // out-of-range sizes clamp; abandoned frames restart cleanly
  task automatic test_clamps();
    set_raster(0, 0);
    send_frame(1, 1, 0);
    set_raster(2047, 1);
    repeat (20) send_texel();
    set_raster(1, 2047);
    repeat (20) send_texel();
    set_raster(1024, 1024);
    repeat (8) send_texel();
    set_raster(1, 1);
    send_frame(1, 1, 1);
  endtask

  task automatic test_random_frames(int idle, int stall, int beats);
    int unsigned w, h;
    int stop_at;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
      h = $urandom_range(7, 1);
      set_raster(w, h);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(w * h)) send_texel();  // abandoned by the next write
      end else begin
        send_frame(w, h, $urandom_range(2) == 0);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off long while the sender keeps going
  task automatic test_backpressure();
    set_raster(8, 6);
    hold_left = 800;
    send_frame(8, 6, 0);
  endtask

  // sender pauses mid-frame until every result has come out
  task automatic test_pause();
    set_raster(5, 4);
    repeat (12) send_texel();
    stop_sending();
    wait (corrected_q.size() == 0);
    repeat (8) send_texel();
    repeat (6) send_flush();
  endtask

  initial begin
    raster_w_reg = MaxWidthDef;
    raster_h_reg = HeightLimit;
    col_pos = 0;
    row_pos = 0;
    waiting_texels = 0;
    frame_draining = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_clamps();
    test_random_frames(0, 0, 450);
    test_random_frames(50, 0, 400);
    test_random_frames(0, 50, 400);
    test_random_frames(36, 36, 400);
    test_backpressure();
    test_pause();
    wait_idle();
    $display("covered %0d input beats, %0d texels checked, %0d frames drained",
             beats_sent, texels_checked, frames_done);
    $display("sizes 1x1 to 40x7, clamped sizes, abandoned frames, stalls and gaps");
    if (error_count == 0 && corrected_q.size() == 0) begin
      $display("[lightmap_coverage_fix_and_dilate_top] OK");
    end else begin
      $display("[lightmap_coverage_fix_and_dilate_top] ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[lightmap_coverage_fix_and_dilate_top] ERROR");
    $finish;
  end

endmodule
